[src/hptc_pkg.sv]
// shared types, constants and helpers of the heading pd turn controller
package hptc_pkg;

  localparam int AngW     = 24;
  localparam int PosW     = 25;
  localparam int TolW     = 16;
  localparam int SpdW     = 15;
  localparam int GainW    = 24;
  localparam int CmdW     = 16;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int PropW    = PosW + GainW + 1;
  localparam int DerivW   = PosW + 1 + GainW + 1;

  localparam logic [OpW-1:0] OP_START_REL = 2'd0;
  localparam logic [OpW-1:0] OP_START_ABS = 2'd1;
  localparam logic [OpW-1:0] OP_SAMPLE    = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET = 3'd0,
    CFG_PROP   = 3'd1,
    CFG_DERIV  = 3'd2,
    CFG_TOL    = 3'd3,
    CFG_MAX    = 3'd4,
    CFG_MIN    = 3'd5
  } cfg_idx_t;

  localparam int HALF_TURN = 18000;
  localparam int FULL_TURN = 36000;

  localparam logic signed [PosW-1:0] SENTINEL_ERR  = 25'sd999990;
  localparam logic [TolW-1:0]        ABS_TOL       = 16'd200;
  localparam logic [TolW-1:0]        RESET_TOL     = 16'd200;
  localparam logic [SpdW-1:0]        RESET_MAX_SPD = 15'h7fff;

  typedef struct packed {
    logic [AngW-1:0]  target_angle;
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] deriv_gain;
    logic [TolW-1:0]  tolerance;
    logic [SpdW-1:0]  spd_ceil;
    logic [SpdW-1:0]  spd_floor;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [PropW-1:0]  prop_term;
    logic [DerivW-1:0] deriv_term;
  } prd_t;

  function automatic logic signed [PosW-1:0] sat25(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi;
    logic signed [PosW+1:0] lo;
    hi = {3'b000, {(PosW-1){1'b1}}};
    lo = {3'b111, {(PosW-1){1'b0}}};
    if (v > hi) begin
      sat25 = hi[PosW-1:0];
    end else if (v < lo) begin
      sat25 = lo[PosW-1:0];
    end else begin
      sat25 = v[PosW-1:0];
    end
  endfunction

endpackage

[src/hptc_in_if.sv]
// input channel: operation code and gyro heading
interface hptc_in_if import hptc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic signed [AngW-1:0] heading;

  modport source (output valid, output operation, output heading, input ready);
  modport sink   (input valid, input operation, input heading, output ready);
endinterface

[src/hptc_out_if.sv]
// result channel: turn command and done flag
interface hptc_out_if import hptc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [CmdW-1:0] turn_command;
  logic                   done_res;

  modport source (output valid, output turn_command, output done_res, input ready);
  modport sink   (input valid, input turn_command, input done_res, output ready);
endinterface

[src/hptc_cfg.sv]
// configuration register file
module hptc_cfg import hptc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_angle <= '0;
      cfg_r.prop_gain    <= '0;
      cfg_r.deriv_gain   <= '0;
      cfg_r.tolerance    <= RESET_TOL;
      cfg_r.spd_ceil     <= RESET_MAX_SPD;
      cfg_r.spd_floor    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET: cfg_r.target_angle <= cfg_wdata[AngW-1:0];
        CFG_PROP:   cfg_r.prop_gain    <= cfg_wdata[GainW-1:0];
        CFG_DERIV:  cfg_r.deriv_gain   <= cfg_wdata[GainW-1:0];
        CFG_TOL:    cfg_r.tolerance    <= cfg_wdata[TolW-1:0];
        CFG_MAX:    cfg_r.spd_ceil     <= cfg_wdata[SpdW-1:0];
        CFG_MIN:    cfg_r.spd_floor    <= cfg_wdata[SpdW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/hptc_core.sv]
// input register, turn state, error update and gain multiplies
module hptc_core import hptc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  hptc_in_if.sink in_if,
  input  cfg_t  cfg,
  output logic  prd_valid,
  output prd_t  prd,
  input  logic  prd_ready
);

  logic                   in_valid_r;
  logic [OpW-1:0]         op_r;
  logic signed [AngW-1:0] hd_r;

  logic signed [AngW-1:0] start_hd_r, start_hd_nxt;
  logic signed [PosW-1:0] wt_r, wt_nxt;
  logic signed [PosW-1:0] prev_r, prev_nxt;
  logic signed [PosW-1:0] eh_r [4];
  logic signed [PosW-1:0] eh_nxt [4];
  logic [TolW-1:0]        tol_r, tol_nxt;
  logic                   turning_r, turning_nxt;

  logic                   prd_valid_r;
  prd_t                   prd_r, prd_nxt;

  logic                   step_adv;
  logic                   is_start, is_abs, settled, run;
  logic signed [PosW-1:0] start_wt, pos_smp, wt_in, prev_in, eh0_in, pos;
  logic signed [PosW+1:0] pos_x, prev_x, wt_x, err_x;
  logic signed [PosW-1:0] wt_new, err;
  logic signed [PosW:0]   derr, hist_diff;
  logic [PosW:0]          hist_mag;
  logic [PosW-1:0]        err_mag;
  logic signed [PropW-1:0]  prop_term;
  logic signed [DerivW-1:0] deriv_term;

  assign step_adv    = in_valid_r && (!prd_valid_r || prd_ready);
  assign in_if.ready = !in_valid_r || step_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r <= in_if.operation;
      hd_r <= in_if.heading;
    end
  end

  always_comb begin
    is_start = (op_r == OP_START_REL) || (op_r == OP_START_ABS);
    is_abs   = (op_r == OP_START_ABS);

    // settling check on the history left by the previous step
    hist_diff = {eh_r[3][PosW-1], eh_r[3]} - {eh_r[0][PosW-1], eh_r[0]};
    hist_mag  = hist_diff[PosW] ? (PosW+1)'(-hist_diff) : hist_diff;
    err_mag   = eh_r[0][PosW-1] ? PosW'(-eh_r[0]) : eh_r[0];
    settled   = (hist_mag <= {{(PosW+1-TolW){1'b0}}, tol_r}) &&
                (err_mag <= {{(PosW-TolW-1){1'b0}}, tol_r, 1'b0});
    run       = is_start || (turning_r && !settled);

    start_wt = is_abs ?
      ({cfg.target_angle[AngW-1], cfg.target_angle} - {hd_r[AngW-1], hd_r}) :
      {cfg.target_angle[AngW-1], cfg.target_angle};
    pos_smp  = {hd_r[AngW-1], hd_r} - {start_hd_r[AngW-1], start_hd_r};

    wt_in   = is_start ? start_wt : wt_r;
    prev_in = is_start ? '0 : prev_r;
    eh0_in  = is_start ? start_wt : eh_r[0];
    pos     = is_start ? '0 : pos_smp;

    // heading wrap correction of the working target
    pos_x  = {{2{pos[PosW-1]}}, pos};
    prev_x = {{2{prev_in[PosW-1]}}, prev_in};
    wt_x   = {{2{wt_in[PosW-1]}}, wt_in};
    if ((pos_x + (PosW+2)'(HALF_TURN) < prev_x) && (wt_x > prev_x)) begin
      wt_new = sat25(wt_x - (PosW+2)'(FULL_TURN));
    end else if ((pos_x - (PosW+2)'(HALF_TURN) > prev_x) && (wt_x < prev_x)) begin
      wt_new = sat25(wt_x + (PosW+2)'(FULL_TURN));
    end else begin
      wt_new = wt_in;
    end

    err_x = {{2{wt_new[PosW-1]}}, wt_new} - pos_x;
    err   = sat25(err_x);
    derr  = {eh0_in[PosW-1], eh0_in} - {err[PosW-1], err};

    prop_term  = err * $signed({1'b0, cfg.prop_gain});
    deriv_term = derr * $signed({1'b0, cfg.deriv_gain});

    prd_nxt.done       = !run;
    prd_nxt.prop_term  = prop_term;
    prd_nxt.deriv_term = deriv_term;

    start_hd_nxt = is_start ? hd_r : start_hd_r;
    turning_nxt  = run;
    tol_nxt      = is_start ? (is_abs ? ABS_TOL : cfg.tolerance) : tol_r;
    if (run) begin
      wt_nxt    = wt_new;
      prev_nxt  = pos;
      eh_nxt[0] = err;
      eh_nxt[1] = eh0_in;
      eh_nxt[2] = is_start ? SENTINEL_ERR : eh_r[1];
      eh_nxt[3] = is_start ? SENTINEL_ERR : eh_r[2];
    end else begin
      wt_nxt    = wt_r;
      prev_nxt  = prev_r;
      eh_nxt[0] = eh_r[0];
      eh_nxt[1] = eh_r[1];
      eh_nxt[2] = eh_r[2];
      eh_nxt[3] = eh_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hd_r <= '0;
      wt_r       <= '0;
      prev_r     <= '0;
      eh_r[0]    <= SENTINEL_ERR;
      eh_r[1]    <= SENTINEL_ERR;
      eh_r[2]    <= SENTINEL_ERR;
      eh_r[3]    <= SENTINEL_ERR;
      tol_r      <= RESET_TOL;
      turning_r  <= 1'b0;
    end else if (step_adv) begin
      start_hd_r <= start_hd_nxt;
      wt_r       <= wt_nxt;
      prev_r     <= prev_nxt;
      eh_r[0]    <= eh_nxt[0];
      eh_r[1]    <= eh_nxt[1];
      eh_r[2]    <= eh_nxt[2];
      eh_r[3]    <= eh_nxt[3];
      tol_r      <= tol_nxt;
      turning_r  <= turning_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_valid_r <= 1'b0;
    end else if (!prd_valid_r || prd_ready) begin
      prd_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_adv) begin
      prd_r <= prd_nxt;
    end
  end

  assign prd_valid = prd_valid_r;
  assign prd       = prd_r;

endmodule

[src/hptc_out.sv]
// speed sum, scaling, clamp and output register
module hptc_out import hptc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic prd_valid,
  input  prd_t prd,
  output logic prd_ready,
  input  cfg_t cfg,
  hptc_out_if.source out_if
);

  localparam int SumW = DerivW + 1;
  localparam int SpfW = SumW - 16;

  logic                   out_valid_r;
  logic signed [CmdW-1:0] cmd_r, cmd_nxt;
  logic                   done_r;
  logic                   load;

  logic signed [SumW-1:0] sum;
  logic signed [SpfW-1:0] spd, maxs, mins;
  logic signed [SpfW-1:0] spd_c;

  assign load      = !out_valid_r || out_if.ready;
  assign prd_ready = load;

  always_comb begin
    sum  = {{(SumW-PropW){prd.prop_term[PropW-1]}}, prd.prop_term} +
           {prd.deriv_term[DerivW-1], prd.deriv_term};
    spd  = sum[SumW-1:16];
    maxs = {{(SpfW-SpdW){1'b0}}, cfg.spd_ceil};
    mins = {{(SpfW-SpdW){1'b0}}, cfg.spd_floor};

    spd_c = spd;
    if (spd_c > maxs) begin
      spd_c = maxs;
    end
    if (spd_c < -maxs) begin
      spd_c = -maxs;
    end
    if ((spd_c > 0) && (spd_c < mins)) begin
      spd_c = mins;
    end
    if ((spd_c < 0) && (spd_c > -mins)) begin
      spd_c = -mins;
    end

    cmd_nxt = prd.done ? '0 : CmdW'(-spd_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= prd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && prd_valid) begin
      cmd_r  <= cmd_nxt;
      done_r <= prd.done;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.turn_command = cmd_r;
  assign out_if.done_res     = done_r;

endmodule

[src/heading_pd_turn_controller.sv]
// top level of the heading pd turn controller
//
// Gyro heading turn controller. A relative or absolute start item latches the
// heading and target and is itself the first control step; each following
// heading sample gives one pd drive command (negated clamped speed, Q1.15),
// until the turn has settled, when a sample returns zero with done set. Every
// item gives exactly one result. One item is taken per clock cycle unless the
// output side holds off ready. Each item goes through the input register, then
// the turn state update with both gain multiplies, then the sum, clamp and
// output register. Configuration must be written only while no item is in
// flight; the block itself does not enforce it.
module heading_pd_turn_controller import hptc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  hptc_in_if.sink             in_if,
  hptc_out_if.source          out_if,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg;
  logic prd_valid;
  prd_t prd;
  logic prd_ready;

  hptc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hptc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg),
    .prd_valid (prd_valid),
    .prd       (prd),
    .prd_ready (prd_ready)
  );

  hptc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .prd_valid (prd_valid),
    .prd       (prd),
    .prd_ready (prd_ready),
    .cfg       (cfg),
    .out_if    (out_if)
  );

endmodule

[bench/heading_pd_turn_controller_test.sv]
// self-checking testbench for the heading pd turn controller
`timescale 1ns / 1ps

module heading_pd_turn_controller_test;
  import hptc_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE = 2'd3;
  localparam longint PosMax = (longint'(1) << (PosW - 1)) - 1;
  localparam longint PosMin = -(longint'(1) << (PosW - 1));
  localparam longint AngMax = (longint'(1) << (AngW - 1)) - 1;
  localparam longint AngMin = -(longint'(1) << (AngW - 1));
  localparam int QuietLimit = 4000;
  localparam int LongHold = 150;
  localparam int PhaseItems = 83;

  typedef struct {
    logic [OpW-1:0]         operation;
    logic signed [AngW-1:0] heading;
  } heading_item_t;

  typedef struct {
    logic signed [CmdW-1:0] turn_command;
    logic                   done_res;
  } drive_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  hptc_in_if heading_ch ();
  hptc_out_if drive_ch ();

  heading_pd_turn_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (heading_ch),
    .out_if    (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  heading_item_t heading_items[$];
  heading_item_t current_item;
  drive_result_t predicted_commands[$];
  drive_result_t want;
  logic offering;
  logic rdy;

  // register copies
  logic signed [AngW-1:0] target_reg;
  logic [GainW-1:0] prop_reg;
  logic [GainW-1:0] deriv_reg;
  logic [TolW-1:0] tol_reg;
  logic [SpdW-1:0] max_reg;
  logic [SpdW-1:0] min_reg;

  // turn state
  logic signed [AngW-1:0] ref_heading;
  logic signed [PosW-1:0] goal;
  logic signed [PosW-1:0] last_pos;
  logic signed [PosW-1:0] err_hist [4];
  logic [TolW-1:0] turn_tol;
  logic turning;

  int send_idle_pct;
  int recv_idle_pct;
  int long_hold_requests;
  int long_hold_served;
  int hold_left;
  int quiet_cycles;
  int mismatches;
  int items_queued;
  int items_accepted;
  int results_seen;
  int turns_started;
  int turns_settled;
  int wrap_fixes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip25(longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  function automatic longint fit_heading(longint v);
    if (v > AngMax) return AngMax;
    if (v < AngMin) return AngMin;
    return v;
  endfunction

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint rand_heading();
    logic signed [AngW-1:0] h;
    h = AngW'($urandom);
    return h;
  endfunction

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic logic signed [CmdW-1:0] drive_step(longint pos);
    longint wt, prev, err, derr, speed, lim, min_mag, neg;
    wt = goal;
    prev = last_pos;
    if (pos + HALF_TURN < prev && wt > prev) begin
      wt = clip25(wt - FULL_TURN);
      wrap_fixes++;
    end else if (pos - HALF_TURN > prev && wt < prev) begin
      wt = clip25(wt + FULL_TURN);
      wrap_fixes++;
    end
    goal = wt[PosW-1:0];
    last_pos = pos[PosW-1:0];
    err = clip25(wt - pos);
    derr = err_hist[0] - err;
    err_hist[3] = err_hist[2];
    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = err[PosW-1:0];
    speed = (err * longint'(prop_reg) + derr * longint'(deriv_reg)) >>> 16;
    lim = max_reg;
    min_mag = min_reg;
    if (speed > lim) speed = lim;
    if (speed < -lim) speed = -lim;
    if (speed > 0 && speed < min_mag) speed = min_mag;
    if (speed < 0 && speed > -min_mag) speed = -min_mag;
    neg = -speed;
    return neg[CmdW-1:0];
  endfunction

  function automatic bit turn_settled();
    longint spread, last_err, tl;
    spread = err_hist[3] - err_hist[0];
    last_err = err_hist[0];
    tl = turn_tol;
    if (spread < 0) spread = -spread;
    if (last_err < 0) last_err = -last_err;
    return spread <= tl && last_err <= 2 * tl;
  endfunction

  function automatic void predict_turn_step(heading_item_t it);
    drive_result_t res;
    longint hd, wide;
    hd = it.heading;
    res.turn_command = '0;
    res.done_res = 1'b1;
    if (it.operation == OP_START_REL || it.operation == OP_START_ABS) begin
      ref_heading = it.heading;
      last_pos = '0;
      if (it.operation == OP_START_REL) begin
        goal = target_reg;
        turn_tol = tol_reg;
      end else begin
        wide = target_reg - hd;
        goal = wide[PosW-1:0];
        turn_tol = ABS_TOL;
      end
      err_hist[0] = goal;
      err_hist[1] = SENTINEL_ERR;
      err_hist[2] = SENTINEL_ERR;
      err_hist[3] = SENTINEL_ERR;
      turning = 1'b1;
      turns_started++;
      res.turn_command = drive_step(0);
      res.done_res = 1'b0;
    end else if (turning) begin
      if (turn_settled()) begin
        turning = 1'b0;
        turns_settled++;
      end else begin
        res.turn_command = drive_step(hd - ref_heading);
        res.done_res = 1'b0;
      end
    end
    predicted_commands.push_back(res);
  endfunction

  task automatic queue_item(logic [OpW-1:0] op, longint hd);
    heading_item_t it;
    it.operation = op;
    it.heading = hd[AngW-1:0];
    heading_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(cfg_idx_t idx, longint val);
    logic [CfgDataW-1:0] data;
    data = val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_TARGET: target_reg = data;
      CFG_PROP:   prop_reg = data;
      CFG_DERIV:  deriv_reg = data;
      CFG_TOL:    tol_reg = data[TolW-1:0];
      CFG_MAX:    max_reg = data[SpdW-1:0];
      CFG_MIN:    min_reg = data[SpdW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(longint t, longint p, longint d, longint tl, longint mx,
                                longint mn);
    write_reg(CFG_TARGET, t);
    write_reg(CFG_PROP, p);
    write_reg(CFG_DERIV, d);
    write_reg(CFG_TOL, tl);
    write_reg(CFG_MAX, mx);
    write_reg(CFG_MIN, mn);
  endtask

  task automatic wait_for_idle();
    while (heading_items.size() != 0 || offering || predicted_commands.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // start, approach with jitter and the odd gyro wrap, then mostly hold on the goal
  task automatic queue_turn();
    logic [OpW-1:0] op;
    longint start_hd, goal_hd, cur, shift;
    op = ($urandom_range(0, 1) == 0) ? OP_START_REL : OP_START_ABS;
    if ($urandom_range(0, 5) == 0) start_hd = rand_heading();
    else start_hd = jitter(200000);
    if (op == OP_START_REL) goal_hd = start_hd + target_reg;
    else goal_hd = target_reg;
    goal_hd = fit_heading(goal_hd);
    queue_item(op, start_hd);
    cur = start_hd;
    repeat ($urandom_range(1, 8)) begin
      cur = cur + (goal_hd - cur) / 2 + jitter(100);
      if ($urandom_range(0, 11) == 0) begin
        shift = ($urandom_range(0, 1) == 0) ? 36000 : -36000;
        cur += shift;
        goal_hd += shift;
      end
      cur = fit_heading(cur);
      queue_item(OP_SAMPLE, cur);
    end
    if ($urandom_range(0, 9) != 0) begin
      repeat ($urandom_range(4, 7)) queue_item(OP_SAMPLE, fit_heading(goal_hd));
      repeat ($urandom_range(1, 2))
        queue_item(($urandom_range(0, 1) == 0) ? OP_SAMPLE : OP_SPARE,
                   fit_heading(goal_hd + jitter(50)));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      heading_ch.valid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (offering && heading_ch.ready) begin
        predict_turn_step(current_item);
        items_accepted++;
        offering = 1'b0;
      end
      if (!offering && heading_items.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        current_item = heading_items.pop_front();
        heading_ch.operation <= current_item.operation;
        heading_ch.heading <= current_item.heading;
        offering = 1'b1;
      end
      heading_ch.valid <= offering;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      drive_ch.ready <= 1'b0;
    end else begin
      if (drive_ch.valid && drive_ch.ready) begin
        results_seen++;
        if (predicted_commands.size() == 0) begin
          log_mismatch($sformatf("unexpected transfer: command %0d done %0b",
                                 drive_ch.turn_command, drive_ch.done_res));
        end else begin
          want = predicted_commands.pop_front();
          if (drive_ch.turn_command !== want.turn_command ||
              drive_ch.done_res !== want.done_res)
            log_mismatch($sformatf("result %0d: expected command %0d done %0b, got %0d done %0b",
                                   results_seen, want.turn_command, want.done_res,
                                   drive_ch.turn_command, drive_ch.done_res));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_served != long_hold_requests) begin
        long_hold_served++;
        hold_left = LongHold;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(0, 99) >= recv_idle_pct);
      end
      drive_ch.ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((heading_ch.valid && heading_ch.ready) || (drive_ch.valid && drive_ch.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               predicted_commands.size());
      $display("heading_pd_turn_controller_test failed");
      $finish;
    end
  end

  initial begin
    longint t, p, d, tl, mx, mn;
    int phase_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TARGET;
    cfg_wdata = '0;
    heading_ch.valid = 1'b0;
    heading_ch.operation = OP_SAMPLE;
    heading_ch.heading = '0;
    drive_ch.ready = 1'b0;
    offering = 1'b0;
    target_reg = '0;
    prop_reg = '0;
    deriv_reg = '0;
    tol_reg = RESET_TOL;
    max_reg = RESET_MAX_SPD;
    min_reg = '0;
    ref_heading = '0;
    goal = '0;
    last_pos = '0;
    for (int i = 0; i < 4; i++) err_hist[i] = SENTINEL_ERR;
    turn_tol = RESET_TOL;
    turning = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 58;
    long_hold_requests = 0;
    long_hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    items_queued = 0;
    items_accepted = 0;
    results_seen = 0;
    turns_started = 0;
    turns_settled = 0;
    wrap_fixes = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // idle samples on reset settings
    queue_item(OP_SAMPLE, 0);
    queue_item(OP_SPARE, AngMin);
    wait_for_idle();

    // full-scale gains, saturated error and target
    apply_settings(AngMax, 24'hffffff, 24'hffffff, 36000, 32767, 0);
    queue_item(OP_START_REL, AngMax);
    queue_item(OP_SAMPLE, AngMin);
    queue_item(OP_SAMPLE, AngMax);
    queue_item(OP_START_ABS, AngMin);
    queue_item(OP_SAMPLE, AngMax);
    wait_for_idle();

    // zero gains and limits
    apply_settings(AngMin, 0, 0, 0, 0, 0);
    queue_item(OP_START_REL, 0);
    queue_item(OP_START_ABS, AngMax);
    queue_item(OP_SAMPLE, AngMin);
    wait_for_idle();

    // downward wrap, settle, idle, then upward wrap
    apply_settings(9000, 8192, 4096, 500, 20000, 3000);
    queue_item(OP_START_REL, 1000);
    queue_item(OP_SAMPLE, -30000);
    repeat (6) queue_item(OP_SAMPLE, -26000);
    queue_item(OP_START_REL, 0);
    queue_item(OP_SAMPLE, 20000);
    queue_item(OP_SAMPLE, 60000);
    wait_for_idle();

    // min above max
    apply_settings(9000, 8192, 4096, 500, 1000, 32767);
    queue_item(OP_START_ABS, 100);
    queue_item(OP_SAMPLE, 9100);

    for (int ph = 0; ph < 6; ph++) begin
      wait_for_idle();
      send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 58 : 0;
      recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 12 : 0;
      t = ($urandom_range(0, 7) == 0) ? rand_heading() : jitter(30000);
      p = ($urandom_range(0, 7) == 0) ? longint'(GainW'($urandom))
                                      : longint'($urandom_range(0, 20000));
      d = ($urandom_range(0, 7) == 0) ? longint'(GainW'($urandom))
                                      : longint'($urandom_range(0, 20000));
      tl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 36000) : $urandom_range(0, 2000);
      mx = $urandom_range(0, 32767);
      mn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 4000);
      apply_settings(t, p, d, tl, mx, mn);
      phase_start = items_queued;
      while (items_queued - phase_start < PhaseItems) begin
        if ($urandom_range(0, 99) < 8)
          queue_item(OpW'($urandom_range(0, 3)), rand_heading());
        else
          queue_turn();
      end
      if (ph == 0 || ph == 5) long_hold_requests++;
    end

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (predicted_commands.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", predicted_commands.size()));
    $display("covered %0d items and %0d results over directed and six random settings",
             items_accepted, results_seen);
    $display("%0d turns started, %0d settled, %0d wrap corrections, %0d long output stalls",
             turns_started, turns_settled, wrap_fixes, long_hold_served);
    if (mismatches == 0) begin
      $display("heading_pd_turn_controller_test passed");
    end else begin
      $display("heading_pd_turn_controller_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/hptc_pkg.sv
src/hptc_in_if.sv
src/hptc_out_if.sv
src/hptc_cfg.sv
src/hptc_core.sv
src/hptc_out.sv
src/heading_pd_turn_controller.sv
bench/heading_pd_turn_controller_test.sv
